// ----- rtl/stlm_pkg.sv -----
// shared types and constants for the sorted two-list insert/merge block
// no dependencies; imported by every module of the block
`default_nettype none
package stlm_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int KEY_WIDTH  = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    REQ_INS_A = 2'd0,
    REQ_INS_B = 2'd1,
    REQ_MERGE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_MERGED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE  = 1'b0,
    FSM_MERGE = 1'b1
  } state_t;

  // per-list command: insert the broadcast key, or shift toward the head
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/stlm_cell.sv -----
// one slot of a sorted list: holds a key, shifts up on insert, down on pop
// depends on stlm_pkg
`default_nettype none
module stlm_cell (
  input  wire                 clk,
  input  stlm_pkg::cell_ctrl_t ctrl,
  input  stlm_pkg::key_t      key_in,
  input  wire                 own_valid,
  input  stlm_pkg::key_t      prev_key,
  input  wire                 prev_ge,
  input  stlm_pkg::key_t      next_key,
  output stlm_pkg::key_t      key,
  output logic                ge
);
  import stlm_pkg::*;

  key_t key_r;
  key_t key_nxt;

  // slot holds a key at or above the new one, so the new key goes at or below here
  assign ge  = own_valid && (key_r >= key_in);
  assign key = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins) begin
      if (prev_ge) begin
        key_nxt = prev_key;
      end else if (ge || !own_valid) begin
        key_nxt = key_in;
      end
    end else if (ctrl.pop) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/stlm_list.sv -----
// one ascending list as a row of stlm_cell slots plus its fill count
// depends on stlm_pkg and stlm_cell
`default_nettype none
module stlm_list (
  input  wire                  clk,
  input  wire                  rst_n,
  input  stlm_pkg::cell_ctrl_t ctrl,
  input  stlm_pkg::key_t       key_in,
  output stlm_pkg::key_t       head,
  output stlm_pkg::cnt_t       cnt
);
  import stlm_pkg::*;

  key_t row_key [LIST_DEPTH];
  logic row_ge  [LIST_DEPTH];
  cnt_t cnt_r;
  cnt_t cnt_nxt;

  genvar i;
  generate
    for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
      key_t p_key;
      logic p_ge;
      key_t n_key;
      if (i == 0) begin : g_first
        assign p_key = key_in;
        assign p_ge  = 1'b0;
      end else begin : g_mid
        assign p_key = row_key[i-1];
        assign p_ge  = row_ge[i-1];
      end
      if (i == LIST_DEPTH - 1) begin : g_last
        assign n_key = row_key[i];
      end else begin : g_inner
        assign n_key = row_key[i+1];
      end
      stlm_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .key_in   (key_in),
        .own_valid(cnt_r > CNT_W'(i)),
        .prev_key (p_key),
        .prev_ge  (p_ge),
        .next_key (n_key),
        .key      (row_key[i]),
        .ge       (row_ge[i])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head = row_key[0];
  assign cnt  = cnt_r;

endmodule
`default_nettype wire

// ----- rtl/sorted_two_list_insert_merge.sv -----
// sorted two-list insert/merge block: two ascending key lists kept in rows of cells.
// in channel: in_req_type / in_key_value with in_valid, in_stall (driven here).
// out channel: out_status, out_key, out_source_list, out_last with out_valid,
//   out_stall (driven by the receiver).
// an insert beat puts the key into list A or B ahead of equal keys, compared
//   against every slot at once; the acknowledge appears the next cycle, so inserts
//   can follow back to back while out_stall is low. a full list drops the key and
//   answers with the dropped status.
// a merge beat drains both lists, one result per cycle while out_stall is low, from
//   the two list heads, smaller head first, list A on ties; out_last marks the final
//   result. the beat only moves the block into the merge state, and each merged result
//   is registered from that state, so the first comes later than an insert acknowledge.
//   both lists empty gives a single empty-status result, like an insert.
// request code 3 is taken and produces nothing.
// one item at a time: in_stall is high during a merge and while a result waits
//   with out_stall high; a stalled result holds until taken.
// reset (rst_n low, synchronous) empties both lists and clears out_valid.
// depends on stlm_pkg, stlm_list
`default_nettype none
module sorted_two_list_insert_merge (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [1:0]           in_req_type,
  input  wire  signed [31:0]   in_key_value,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [1:0]           out_status,
  output logic signed [31:0]   out_key,
  output logic                 out_source_list,
  output logic                 out_last
);
  import stlm_pkg::*;

  state_t     state_r, state_nxt;
  cell_ctrl_t ctrl_a, ctrl_b;
  key_t       head_a, head_b, key_in;
  cnt_t       cnt_a, cnt_b;
  logic       out_free, in_fire, take_a, load;
  logic       out_valid_r;
  status_t    status_r, status_nxt;
  key_t       key_r, key_nxt;
  logic       src_r, src_nxt;
  logic       last_r, last_nxt;
  req_t       req;

  assign key_in   = key_t'(in_key_value);
  assign req      = req_t'(in_req_type);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == FSM_IDLE) && out_free);
  assign in_fire  = in_valid && !in_stall;
  assign take_a   = (cnt_a != '0) && ((cnt_b == '0) || (head_a <= head_b));

  stlm_list u_list_a (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl_a), .key_in(key_in), .head(head_a), .cnt(cnt_a)
  );
  stlm_list u_list_b (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl_b), .key_in(key_in), .head(head_b), .cnt(cnt_b)
  );

  always_comb begin
    state_nxt  = state_r;
    ctrl_a     = '0;
    ctrl_b     = '0;
    load       = 1'b0;
    status_nxt = ST_INSERTED;
    key_nxt    = key_in;
    src_nxt    = 1'b0;
    last_nxt   = 1'b1;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          case (req)
            REQ_INS_A: begin
              load = 1'b1;
              if (cnt_a == CNT_W'(LIST_DEPTH)) begin
                status_nxt = ST_DROPPED;
              end else begin
                ctrl_a.ins = 1'b1;
              end
            end
            REQ_INS_B: begin
              load    = 1'b1;
              src_nxt = 1'b1;
              if (cnt_b == CNT_W'(LIST_DEPTH)) begin
                status_nxt = ST_DROPPED;
              end else begin
                ctrl_b.ins = 1'b1;
              end
            end
            REQ_MERGE: begin
              if (cnt_a == '0 && cnt_b == '0) begin
                load       = 1'b1;
                status_nxt = ST_EMPTY;
                key_nxt    = '0;
              end else begin
                state_nxt = FSM_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_MERGE: begin
        if (out_free) begin
          load       = 1'b1;
          status_nxt = ST_MERGED;
          ctrl_a.pop = take_a;
          ctrl_b.pop = !take_a;
          key_nxt    = take_a ? head_a : head_b;
          src_nxt    = !take_a;
          // one key left across both lists
          last_nxt   = ({1'b0, cnt_a} + {1'b0, cnt_b}) == (CNT_W + 1)'(1);
          if (last_nxt) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      key_r    <= key_nxt;
      src_r    <= src_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_key         = key_r;
  assign out_source_list = src_r;
  assign out_last        = last_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a <= CNT_W'(LIST_DEPTH)) && (cnt_b <= CNT_W'(LIST_DEPTH)))
    else $error("list count above depth");
  a_merge_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_MERGE) |-> (cnt_a != '0 || cnt_b != '0))
    else $error("merge running with both lists empty");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (state_r == FSM_IDLE))
    else $error("beat accepted during merge");
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_INS_A && cnt_a != CNT_W'(LIST_DEPTH))
      |=> (cnt_a == $past(cnt_a) + CNT_W'(1)))
    else $error("insert into list a did not grow it");
`endif

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for sorted_two_list_insert_merge: directed and random insert/merge
// traffic with random stalls on both channels; results checked by a scoreboard class
// depends on stlm_pkg and the rtl of sorted_two_list_insert_merge
`timescale 1ns / 1ps
module tb;
  import stlm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_ITEMS    = 460;
  localparam int QUIET_ITEMS    = 60;

  typedef struct {
    status_t st;
    key_t    key;
    logic    src;
    logic    last;
  } list_result_t;

  // shadow of both lists; every accepted insert or merge beat turns into expected results
  class sorted_list_tracker;
    key_t         lists [2][LIST_DEPTH];
    int unsigned  fill [2];
    list_result_t pending_results [$];
    int unsigned  mismatches;

    function new();
      fill[0] = 0;
      fill[1] = 0;
      mismatches = 0;
    endfunction

    function void push(status_t st, key_t key, logic src, logic last);
      list_result_t r;
      r.st = st;
      r.key = key;
      r.src = src;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void take_request(logic [1:0] req, key_t key);
      int unsigned sel;
      int unsigned pos;
      int unsigned ia;
      int unsigned ib;
      int          i;
      logic        take_a;
      key_t        v;
      case (req)
        REQ_INS_A, REQ_INS_B: begin
          sel = (req == REQ_INS_B) ? 1 : 0;
          if (fill[sel] >= LIST_DEPTH) begin
            push(ST_DROPPED, key, sel[0], 1'b1);
          end else begin
            // new key goes ahead of any equal ones
            pos = 0;
            while (pos < fill[sel] && lists[sel][pos] < key) pos++;
            for (i = fill[sel]; i > pos; i--) lists[sel][i] = lists[sel][i-1];
            lists[sel][pos] = key;
            fill[sel]++;
            push(ST_INSERTED, key, sel[0], 1'b1);
          end
        end
        REQ_MERGE: begin
          if (fill[0] == 0 && fill[1] == 0) begin
            push(ST_EMPTY, key_t'(0), 1'b0, 1'b1);
          end else begin
            ia = 0;
            ib = 0;
            while (ia < fill[0] || ib < fill[1]) begin
              // list a wins ties
              take_a = (ia < fill[0]) && (ib >= fill[1] || lists[0][ia] <= lists[1][ib]);
              if (take_a) begin
                v = lists[0][ia];
                ia++;
              end else begin
                v = lists[1][ib];
                ib++;
              end
              push(ST_MERGED, v, !take_a, (ia >= fill[0] && ib >= fill[1]));
            end
            fill[0] = 0;
            fill[1] = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] st, key_t key, logic src, logic last);
      list_result_t e;
      if (pending_results.size() == 0) begin
        flag($sformatf("unexpected result st=%0d key=%0d src=%0b last=%0b",
                       st, key, src, last));
      end else begin
        e = pending_results.pop_front();
        if (st !== e.st || key !== e.key || src !== e.src || last !== e.last)
          flag($sformatf("expected st=%0d key=%0d src=%0b last=%0b, got st=%0d key=%0d src=%0b last=%0b",
                         e.st, e.key, e.src, e.last, st, key, src, last));
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_NONE;
  key_t        in_key_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  key_t        out_key;
  logic        out_source_list;
  logic        out_last;

  sorted_list_tracker tracker;
  int unsigned items_sent = 0;
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  sorted_two_list_insert_merge u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_key_value    (in_key_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_key         (out_key),
    .out_source_list (out_source_list),
    .out_last        (out_last)
  );

  initial begin
    tracker = new();
    forever #1 clk = ~clk;
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
        stall_left = $urandom_range(1, 11);
    end
  end

  // request beat is noted before any result of the same edge is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_request(in_req_type, in_key_value);
      if (out_valid && !out_stall)
        tracker.check_result(out_status, out_key, out_source_list, out_last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic idle_burst();
    int unsigned n;
    n = $urandom_range(1, 11);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_key_value <= key_t'($urandom);
    end
  endtask

  task automatic send_req(logic [1:0] req, key_t key);
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_key_value <= key;
    do @(posedge clk); while (in_stall);
    if (req != REQ_NONE) items_sent++;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) idle_burst();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  function automatic key_t next_key(int unsigned mode);
    key_t k;
    case (mode)
      0: k = key_t'(int'($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 5))
          0: k = key_t'(32'h8000_0000);
          1: k = key_t'(32'h7fff_ffff);
          2: k = key_t'(32'h8000_0001);
          3: k = key_t'(32'h7fff_fffe);
          4: k = key_t'(0);
          default: k = key_t'(-1);
        endcase
      end
      default: k = key_t'($urandom);
    endcase
    return k;
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 5);
    if (r < 9) return $urandom_range(6, 15);
    return $urandom_range(16, 19);
  endfunction

  // a batch fills both lists in random interleave, then usually merges
  task automatic run_batch();
    int unsigned na;
    int unsigned nb;
    int unsigned la;
    int unsigned lb;
    int unsigned mode;
    logic        to_b;
    na = pick_size();
    nb = pick_size();
    la = 0;
    lb = 0;
    mode = $urandom_range(0, 3);
    tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
    rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
    if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS) begin
      tx_gap_pct = 0;
      rx_stall_pct = 0;
    end
    while (la < na || lb < nb) begin
      if (la >= na) to_b = 1'b1;
      else if (lb >= nb) to_b = 1'b0;
      else to_b = $urandom_range(0, 1);
      if ($urandom_range(0, 19) == 0) send_req(REQ_NONE, key_t'($urandom));
      if (to_b) begin
        send_req(REQ_INS_B, next_key(mode));
        lb++;
      end else begin
        send_req(REQ_INS_A, next_key(mode));
        la++;
      end
    end
    // now and then leave the lists filled into the next batch
    if ($urandom_range(0, 9) != 0) send_req(REQ_MERGE, key_t'($urandom));
    if ($urandom_range(0, 14) == 0) send_req(REQ_MERGE, key_t'($urandom));
  endtask

  initial begin
    logic paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_gap_pct = 20;
    rx_stall_pct = 15;
    send_req(REQ_MERGE, key_t'(32'h1234_5678));
    send_req(REQ_INS_A, key_t'(32'h7fff_ffff));
    send_req(REQ_INS_A, key_t'(32'h8000_0000));
    send_req(REQ_INS_A, key_t'(-1));
    send_req(REQ_INS_A, key_t'(5));
    send_req(REQ_INS_A, key_t'(5));
    send_req(REQ_INS_B, key_t'(5));
    send_req(REQ_INS_B, key_t'(32'h8000_0000));
    send_req(REQ_INS_B, key_t'(32'h7fff_ffff));
    send_req(REQ_INS_B, key_t'(0));
    send_req(REQ_NONE, key_t'(32'hffff_ffff));
    send_req(REQ_MERGE, key_t'(0));
    send_req(REQ_INS_B, key_t'(32'h5555_aaaa));
    send_req(REQ_MERGE, key_t'(32'hffff_ffff));

    while (items_sent < TOTAL_ITEMS) begin
      run_batch();
      if (!paused && items_sent >= TOTAL_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/stlm_pkg.sv
rtl/stlm_cell.sv
rtl/stlm_list.sv
rtl/sorted_two_list_insert_merge.sv
tb/tb.sv
